// ===== hw/rtl/tve_pkg.sv =====
// Shared types and constants of the template variable expander.
package tve_pkg;

  localparam int NAME_CW = 6;

  typedef enum logic [1:0] {
    KIND_LIT   = 2'd0,
    KIND_NAME  = 2'd1,
    KIND_EMPTY = 2'd2,
    KIND_END   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       first_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] out_byte;
    logic       name_end;
    logic       name_truncated;
    logic       run_last;
  } out_t;

  // Result plan of one input item, in output order: A, B, name run, C, end marker.
  typedef struct packed {
    logic               lit_a_en;
    logic [7:0]         lit_a;
    logic               lit_b_en;
    logic [7:0]         lit_b;
    logic               run_en;
    logic               run_name;
    logic [NAME_CW-1:0] run_cnt;
    logic               run_ovf;
    logic               lit_c_en;
    logic [7:0]         lit_c;
    logic               end_en;
  } plan_t;

endpackage

// ===== hw/rtl/template_variable_expand_top.sv =====
// Top level of the template variable expander.
//
//   channel | ports                           | payload
//   --------+---------------------------------+----------------------------------
//   input   | in_valid, in_stall, in_data     | text_byte, first_byte, final_byte
//   output  | out_valid, out_stall, out_data  | kind, out_byte, name_end,
//           |                                 | name_truncated, run_last
//
// Each result of an item leaves the output register one per cycle while out_stall is low;
// in_stall is high while results beyond the last one are still to go. Name runs are
// replayed from the name store at one byte per cycle, likewise while out_stall is low,
// through its registered read port.
// Reset (rst_n low, synchronous) returns to normal text outside a phrase, empty name.
// out_stall holds the output register and, behind it, the sequencer.
module template_variable_expand_top #(
  parameter int MAX_NAME = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  tve_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output tve_pkg::out_t out_data
);

  localparam int AW = (MAX_NAME > 1) ? $clog2(MAX_NAME) : 1;

  tve_pkg::plan_t plan;
  logic           accept;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  logic [7:0]     mem_wdata, mem_rdata;

  assign accept = in_valid && !in_stall;

  tve_scan #(
    .MAX_NAME (MAX_NAME),
    .AW       (AW)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_data   (in_data),
    .plan      (plan),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata)
  );

  tve_name_mem #(
    .DEPTH (MAX_NAME),
    .AW    (AW)
  ) u_name_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tve_emit #(
    .AW (AW)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .plan      (plan),
    .rd_data   (mem_rdata),
    .rd_addr   (mem_raddr),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/tve_name_mem.sv =====
// Name byte store: one write port, one registered read port with write forwarding.
module tve_name_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // a byte pushed in the same cycle is seen by the read of that entry
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/tve_scan.sv =====
// Phrase scanner: scan state, name count and the result plan of each item.
module tve_scan #(
  parameter int MAX_NAME = 32,
  parameter int AW       = 5
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  tve_pkg::in_t   in_data,
  output tve_pkg::plan_t plan,
  output logic           mem_we,
  output logic [AW-1:0]  mem_waddr,
  output logic [7:0]     mem_wdata
);

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [tve_pkg::NAME_CW-1:0] LIMIT = tve_pkg::NAME_CW'(MAX_NAME);

  typedef enum logic [1:0] {
    ST_NORMAL,
    ST_START,
    ST_BRACED,
    ST_VAR
  } scan_st_t;

  function automatic logic is_alpha(input logic [7:0] ch);
    return ch inside {[8'h61:8'h7A], [8'h41:8'h5A], CH_UNDER};
  endfunction

  function automatic logic is_name_char(input logic [7:0] ch);
    return is_alpha(ch) || (ch inside {[8'h30:8'h39]});
  endfunction

  scan_st_t                    st_r, st_nxt;
  logic                        dyn_r, dyn_nxt;
  logic [tve_pkg::NAME_CW-1:0] cnt_r, cnt_nxt, cnt_base;
  logic                        ovf_r, ovf_nxt, ovf_base;
  logic                        do_clear, do_push, push_wr;
  logic [7:0]                  c;

  assign c = in_data.text_byte;

  always_comb begin
    plan     = '0;
    st_nxt   = st_r;
    dyn_nxt  = dyn_r;
    do_clear = 1'b0;
    do_push  = 1'b0;
    push_wr  = 1'b0;

    if (in_data.first_byte) begin
      st_nxt   = ST_NORMAL;
      do_clear = 1'b1;
      dyn_nxt  = (c == CH_HASH);
      if (c != CH_HASH) begin
        plan.lit_a_en = 1'b1;
        plan.lit_a    = c;
      end
    end else if (dyn_r) begin
      case (st_r)
        ST_NORMAL: begin
          if (c == CH_DOLLAR) begin
            st_nxt = ST_START;
          end else begin
            plan.lit_a_en = 1'b1;
            plan.lit_a    = c;
          end
        end
        ST_START: begin
          if (c == CH_LBRACE) begin
            do_clear = 1'b1;
            st_nxt   = ST_BRACED;
          end else if (c == CH_DOLLAR) begin
            plan.lit_a_en = 1'b1;
            plan.lit_a    = CH_DOLLAR;
            st_nxt        = ST_NORMAL;
          end else if (is_alpha(c)) begin
            do_clear = 1'b1;
            do_push  = 1'b1;
            st_nxt   = ST_VAR;
          end else begin
            plan.lit_a_en = 1'b1;
            plan.lit_a    = CH_DOLLAR;
            plan.lit_b_en = 1'b1;
            plan.lit_b    = c;
            st_nxt        = ST_NORMAL;
          end
        end
        ST_BRACED: begin
          if (c == CH_RBRACE) begin
            plan.run_en   = 1'b1;
            plan.run_name = 1'b1;
            st_nxt        = ST_NORMAL;
          end else begin
            do_push = 1'b1;
          end
        end
        ST_VAR: begin
          if (is_name_char(c)) begin
            do_push = 1'b1;
          end else begin
            plan.run_en   = 1'b1;
            plan.run_name = 1'b1;
            if (c == CH_DOLLAR) begin
              st_nxt = ST_START;
            end else begin
              st_nxt        = ST_NORMAL;
              plan.lit_c_en = 1'b1;
              plan.lit_c    = c;
            end
          end
        end
        default: begin
          st_nxt = ST_NORMAL;
        end
      endcase
    end else begin
      plan.lit_a_en = 1'b1;
      plan.lit_a    = c;
    end

    cnt_base = do_clear ? '0 : cnt_r;
    ovf_base = do_clear ? 1'b0 : ovf_r;
    cnt_nxt  = cnt_base;
    ovf_nxt  = ovf_base;
    if (do_push) begin
      if (cnt_base < LIMIT) begin
        push_wr = 1'b1;
        cnt_nxt = cnt_base + tve_pkg::NAME_CW'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    plan.run_cnt = cnt_nxt;
    plan.run_ovf = ovf_nxt;

    // phrase end: flush what is pending, then the end marker
    if (in_data.final_byte) begin
      if (dyn_nxt) begin
        case (st_nxt)
          ST_START: begin
            if (plan.run_en) begin
              plan.lit_c_en = 1'b1;
              plan.lit_c    = CH_DOLLAR;
            end else begin
              plan.lit_a_en = 1'b1;
              plan.lit_a    = CH_DOLLAR;
            end
          end
          ST_BRACED: begin
            plan.lit_a_en = 1'b1;
            plan.lit_a    = CH_DOLLAR;
            plan.lit_b_en = 1'b1;
            plan.lit_b    = CH_LBRACE;
            plan.run_en   = (cnt_nxt != '0);
            plan.run_name = 1'b0;
          end
          ST_VAR: begin
            plan.run_en   = 1'b1;
            plan.run_name = 1'b1;
          end
          default: begin
          end
        endcase
      end
      plan.end_en = 1'b1;
      st_nxt      = ST_NORMAL;
      dyn_nxt     = 1'b0;
      cnt_nxt     = '0;
      ovf_nxt     = 1'b0;
    end
  end

  assign mem_we    = accept && push_wr;
  assign mem_waddr = cnt_base[AW-1:0];
  assign mem_wdata = c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_NORMAL;
      dyn_r <= 1'b0;
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else if (accept) begin
      st_r  <= st_nxt;
      dyn_r <= dyn_nxt;
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LIMIT)
    else $error("name count beyond limit");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (cnt_r == LIMIT))
    else $error("overflow flagged on a name that is not full");

  a_literal_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !dyn_r |-> ((st_r == ST_NORMAL) && (cnt_r == '0) && !ovf_r))
    else $error("scan state pending outside a dynamic phrase");
`endif

endmodule

// ===== hw/rtl/tve_emit.sv =====
// Result sequencer: walks the plan of one item and drives the output register.
module tve_emit #(
  parameter int AW = 5
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  tve_pkg::plan_t plan,
  input  logic [7:0]     rd_data,
  output logic [AW-1:0]  rd_addr,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output tve_pkg::out_t  out_data
);

  tve_pkg::plan_t plan_r, rem;
  tve_pkg::out_t  out_data_r, item;
  logic           busy_r, out_valid_r;
  logic [AW-1:0]  idx_r, idx_nxt;
  logic           advance, emit, last, step_idx, at_end;

  assign advance = !out_valid_r || !out_stall;
  assign emit    = busy_r && advance;

  always_comb begin
    item     = '0;
    rem      = plan_r;
    step_idx = 1'b0;
    at_end   = ((tve_pkg::NAME_CW'(idx_r) + tve_pkg::NAME_CW'(1)) == plan_r.run_cnt);
    if (plan_r.lit_a_en) begin
      item.kind     = tve_pkg::KIND_LIT;
      item.out_byte = plan_r.lit_a;
      rem.lit_a_en  = 1'b0;
    end else if (plan_r.lit_b_en) begin
      item.kind     = tve_pkg::KIND_LIT;
      item.out_byte = plan_r.lit_b;
      rem.lit_b_en  = 1'b0;
    end else if (plan_r.run_en) begin
      if (plan_r.run_cnt == '0) begin
        item.kind     = tve_pkg::KIND_EMPTY;
        item.name_end = 1'b1;
        rem.run_en    = 1'b0;
      end else begin
        item.kind           = plan_r.run_name ? tve_pkg::KIND_NAME : tve_pkg::KIND_LIT;
        item.out_byte       = rd_data;
        item.name_end       = plan_r.run_name && at_end;
        item.name_truncated = plan_r.run_name && at_end && plan_r.run_ovf;
        if (at_end) begin
          rem.run_en = 1'b0;
        end else begin
          step_idx = 1'b1;
        end
      end
    end else if (plan_r.lit_c_en) begin
      item.kind     = tve_pkg::KIND_LIT;
      item.out_byte = plan_r.lit_c;
      rem.lit_c_en  = 1'b0;
    end else begin
      item.kind  = tve_pkg::KIND_END;
      rem.end_en = 1'b0;
    end
    last          = !(rem.lit_a_en || rem.lit_b_en || rem.run_en || rem.lit_c_en || rem.end_en);
    item.run_last = last;
  end

  // a new item is taken in the cycle the previous plan hands out its last result
  assign in_stall = busy_r && !(emit && last);

  always_comb begin
    if (accept) begin
      idx_nxt = '0;
    end else if (emit && step_idx) begin
      idx_nxt = idx_r + AW'(1);
    end else begin
      idx_nxt = idx_r;
    end
  end

  // read one entry ahead so rd_data always matches idx_r
  assign rd_addr = idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        busy_r <= plan.lit_a_en || plan.lit_b_en || plan.run_en || plan.lit_c_en
                  || plan.end_en;
      end else if (emit && last) begin
        busy_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (accept) begin
      plan_r <= plan;
    end else if (emit) begin
      plan_r <= rem;
    end
    if (emit) begin
      out_data_r <= item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && plan_r.run_en && (plan_r.run_cnt != '0))
      |-> (tve_pkg::NAME_CW'(idx_r) < plan_r.run_cnt))
    else $error("name run index past stored count");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.kind == tve_pkg::KIND_END)) |-> out_data_r.run_last)
    else $error("end marker is not the last result of its item");

  a_trunc_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.name_truncated) |-> out_data_r.name_end)
    else $error("truncation flag away from name end");
`endif

endmodule
